>>> sv/hsv_to_rgb_converter_defines.svh
// ----------------------------------------------------------------------------
// HSV to RGB converter assertion macros
// Shared assertion forms for the converter checker.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_DEFINES_SVH

// Same-cycle implication, masked while in reset
`define HSVR_ASSERT_IMPL(name, clk, rstn, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("hsvr assertion failed");

// Next-cycle implication, masked while in reset
`define HSVR_ASSERT_NEXT(name, clk, rstn, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("hsvr assertion failed");

// Condition that must hold in the cycle after reset is seen
`define HSVR_ASSERT_RST(name, clk, rstn, post) \
    name: assert property (@(posedge clk) !(rstn) |=> (post)) \
        else $error("hsvr reset assertion failed");

`endif

>>> sv/hsvr_pkg.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Widths, scale constants, sector codes and pipeline stage payload types.
// ----------------------------------------------------------------------------
package hsvr_pkg;

    localparam int HUE_W      = 13;
    localparam int CH_W       = 8;
    localparam int REM_W      = 10;
    localparam int PROD_W     = 18;   // rem*s and 244800 - rem*s
    localparam int PS_W       = 16;   // v*(255-s)
    localparam int MUL_W      = 26;   // v*(244800 - rem*s)
    localparam int Y_W        = 20;   // MUL_W value after dropping 2^6
    localparam int RECIP_W    = 21;

    localparam int HUE_TURN    = 5760;
    localparam int SECTOR_SPAN = 960;
    localparam int NUM_SECTORS = 6;
    localparam int UNIT_SCALE  = 255;
    localparam int FRAC_SCALE  = SECTOR_SPAN * UNIT_SCALE;  // 244800 = 3825 << 6

    // floor(x/244800) = floor((x>>6) * ceil(2^32/3825) >> 32) for x>>6 < 2^20
    localparam int FRAC_SHIFT  = 6;
    localparam int RECIP_SHIFT = 32;
    localparam logic [RECIP_W-1:0] FRAC_RECIP = RECIP_W'(1122868);

    // Hue sectors, 60 degrees each
    typedef enum logic [2:0] {
        SEC_R_Y = 3'd0,
        SEC_Y_G = 3'd1,
        SEC_G_C = 3'd2,
        SEC_C_B = 3'd3,
        SEC_B_M = 3'd4,
        SEC_M_R = 3'd5
    } t_sector;

    // After sector split
    typedef struct packed {
        t_sector           sector;
        logic [REM_W-1:0]  rem;
        logic [CH_W-1:0]   sat;
        logic [CH_W-1:0]   val;
    } t_s1;

    // After first products
    typedef struct packed {
        t_sector           sector;
        logic [CH_W-1:0]   val;
        logic [PROD_W-1:0] qa;    // rem*s
        logic [PROD_W-1:0] ta;    // (960-rem)*s
        logic [PS_W-1:0]   ps;    // v*(255-s)
    } t_s2;

    // After second products
    typedef struct packed {
        t_sector           sector;
        logic [CH_W-1:0]   val;
        logic [CH_W-1:0]   p;
        logic [MUL_W-1:0]  mq;
        logic [MUL_W-1:0]  mt;
    } t_s3;

endpackage

>>> sv/hsvr_hsv_if.sv
// ----------------------------------------------------------------------------
// HSV input channel
// Valid/ready channel carrying hue, saturation and brightness.
// ----------------------------------------------------------------------------
interface hsvr_hsv_if
    import hsvr_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [HUE_W-1:0]  hue;
    logic [CH_W-1:0]   saturation;
    logic [CH_W-1:0]   brightness;

    modport source (output valid, hue, saturation, brightness, input ready);
    modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

>>> sv/hsvr_rgb_if.sv
// ----------------------------------------------------------------------------
// RGB output channel
// Valid/ready channel carrying the red, green and blue intensities.
// ----------------------------------------------------------------------------
interface hsvr_rgb_if
    import hsvr_pkg::*;
;
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

>>> sv/hsvr_sector.sv
// ----------------------------------------------------------------------------
// HSV to RGB sector split stage
// Wraps hue to one turn and splits it into sector and in-sector remainder.
// ----------------------------------------------------------------------------
module hsvr_sector
    import hsvr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [HUE_W-1:0]  i_hue,
    input  logic [CH_W-1:0]   i_sat,
    input  logic [CH_W-1:0]   i_val,
    output logic              o_valid,
    input  logic              i_ready,
    output t_s1               o_data
);

    logic             r_valid;
    t_s1              r_data;
    t_s1              n_data;
    logic [HUE_W-1:0] hue_w;
    logic [HUE_W-1:0] base;
    logic [2:0]       sec;

    // Stage takes a new transaction when empty or draining
    assign o_ready = !r_valid || i_ready;

    // Wrap once: the largest 13-bit hue minus one turn is below one turn
    always_comb begin
        hue_w = (i_hue >= HUE_W'(HUE_TURN)) ? i_hue - HUE_W'(HUE_TURN) : i_hue;
        sec   = 3'd0;
        base  = '0;
        for (int i = 1; i < NUM_SECTORS; i++) begin
            if (hue_w >= HUE_W'(i * SECTOR_SPAN)) begin
                sec  = 3'(i);
                base = HUE_W'(i * SECTOR_SPAN);
            end
        end
        n_data.sector = t_sector'(sec);
        n_data.rem    = REM_W'(hue_w - base);
        n_data.sat    = i_sat;
        n_data.val    = i_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> sv/hsvr_scale.sv
// ----------------------------------------------------------------------------
// HSV to RGB scaling stages
// Two multiply stages: saturation products, then brightness products and p.
// ----------------------------------------------------------------------------
module hsvr_scale
    import hsvr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_s1  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_s3  o_data
);

    logic                r_v2;
    logic                r_v3;
    t_s2                 r_s2;
    t_s2                 n_s2;
    t_s3                 r_s3;
    t_s3                 n_s3;
    logic                rdy2;
    logic                rdy3;
    logic [PS_W:0]       p_sum;

    // Per-stage ready so bubbles collapse
    assign rdy3    = !r_v3 || i_ready;
    assign rdy2    = !r_v2 || rdy3;
    assign o_ready = rdy2;

    // Stage 2: products with saturation
    always_comb begin
        n_s2.sector = i_data.sector;
        n_s2.val    = i_data.val;
        n_s2.qa     = PROD_W'(i_data.rem) * PROD_W'(i_data.sat);
        n_s2.ta     = (PROD_W'(SECTOR_SPAN) - PROD_W'(i_data.rem)) * PROD_W'(i_data.sat);
        n_s2.ps     = PS_W'(i_data.val) * (PS_W'(UNIT_SCALE) - PS_W'(i_data.sat));
    end

    // Stage 3: products with brightness; p = ps/255, exact for ps up to 255*255
    always_comb begin
        p_sum       = (PS_W + 1)'(r_s2.ps) + (PS_W + 1)'(r_s2.ps >> CH_W) + (PS_W + 1)'(1);
        n_s3.sector = r_s2.sector;
        n_s3.val    = r_s2.val;
        n_s3.p      = p_sum[CH_W +: CH_W];
        n_s3.mq     = MUL_W'(r_s2.val) * MUL_W'(PROD_W'(FRAC_SCALE) - r_s2.qa);
        n_s3.mt     = MUL_W'(r_s2.val) * MUL_W'(PROD_W'(FRAC_SCALE) - r_s2.ta);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy2) begin
                r_v2 <= i_valid;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && i_valid) begin
            r_s2 <= n_s2;
        end
        if (rdy3 && r_v2) begin
            r_s3 <= n_s3;
        end
    end

    assign o_valid = r_v3;
    assign o_data  = r_s3;

endmodule

>>> sv/hsvr_divsel.sv
// ----------------------------------------------------------------------------
// HSV to RGB divide and select stage
// Divides by 244800 through a reciprocal multiply and orders the channels.
// ----------------------------------------------------------------------------
module hsvr_divsel
    import hsvr_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  t_s3             i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [CH_W-1:0] o_red,
    output logic [CH_W-1:0] o_green,
    output logic [CH_W-1:0] o_blue
);

    localparam int RP_W = Y_W + RECIP_W;

    logic            r_valid;
    logic [CH_W-1:0] r_red;
    logic [CH_W-1:0] r_green;
    logic [CH_W-1:0] r_blue;
    logic [CH_W-1:0] n_red;
    logic [CH_W-1:0] n_green;
    logic [CH_W-1:0] n_blue;
    logic [RP_W-1:0] q_prod;
    logic [RP_W-1:0] t_prod;
    logic [CH_W-1:0] q;
    logic [CH_W-1:0] t;
    logic [CH_W-1:0] v;
    logic [CH_W-1:0] p;

    assign o_ready = !r_valid || i_ready;

    // Reciprocal divide: quotient never exceeds brightness
    always_comb begin
        q_prod = RP_W'(i_data.mq[FRAC_SHIFT +: Y_W]) * RP_W'(FRAC_RECIP);
        t_prod = RP_W'(i_data.mt[FRAC_SHIFT +: Y_W]) * RP_W'(FRAC_RECIP);
        q      = q_prod[RECIP_SHIFT +: CH_W];
        t      = t_prod[RECIP_SHIFT +: CH_W];
        v      = i_data.val;
        p      = i_data.p;
    end

    // Sector picks the channel order
    always_comb begin
        unique case (i_data.sector)
            SEC_Y_G: begin n_red = q; n_green = v; n_blue = p; end
            SEC_G_C: begin n_red = p; n_green = v; n_blue = t; end
            SEC_C_B: begin n_red = p; n_green = q; n_blue = v; end
            SEC_B_M: begin n_red = t; n_green = p; n_blue = v; end
            SEC_M_R: begin n_red = v; n_green = p; n_blue = q; end
            default: begin n_red = v; n_green = t; n_blue = p; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign o_valid = r_valid;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

>>> sv/hsv_to_rgb_converter.sv
// Each input transaction passes through four register stages to the output.
// Throughput: one transaction per clock while o_rgb.ready is not held low;
// the slowest stage holds one 8x18 multiply or one 20x21 reciprocal multiply.
// Each stage has its own valid bit, so bubbles are squeezed out on stalls.
// Reset (synchronous, active low) clears all valid bits; data is not reset.
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Pipelined conversion of hue/saturation/brightness to 8-bit RGB.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter
    import hsvr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    hsvr_hsv_if.sink    i_pix,
    hsvr_rgb_if.source  o_rgb
);

    logic s1_valid;
    logic s1_ready;
    t_s1  s1_data;
    logic s3_valid;
    logic s3_ready;
    t_s3  s3_data;

    // Sector split
    hsvr_sector u_sector (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_pix.valid),
        .o_ready (i_pix.ready),
        .i_hue   (i_pix.hue),
        .i_sat   (i_pix.saturation),
        .i_val   (i_pix.brightness),
        .o_valid (s1_valid),
        .i_ready (s1_ready),
        .o_data  (s1_data)
    );

    // Products
    hsvr_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_data  (s1_data),
        .o_valid (s3_valid),
        .i_ready (s3_ready),
        .o_data  (s3_data)
    );

    // Divide and channel order
    hsvr_divsel u_divsel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s3_valid),
        .o_ready (s3_ready),
        .i_data  (s3_data),
        .o_valid (o_rgb.valid),
        .i_ready (o_rgb.ready),
        .o_red   (o_rgb.red),
        .o_green (o_rgb.green),
        .o_blue  (o_rgb.blue)
    );

endmodule

>>> sv/hsvr_checker.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter checker
// Port-level assertions on reset, stall hold and input readiness.
// ----------------------------------------------------------------------------
`include "hsv_to_rgb_converter_defines.svh"

module hsvr_checker
    import hsvr_pkg::*;
(
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_ready,
    input logic            i_out_valid,
    input logic            i_out_ready,
    input logic [CH_W-1:0] i_red,
    input logic [CH_W-1:0] i_green,
    input logic [CH_W-1:0] i_blue
);

    // Reset empties the pipeline
    `HSVR_ASSERT_RST(a_rst_empty, i_clk, i_rst_n, !i_out_valid)

    // A stalled result stays put
    `HSVR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_red) && $stable(i_green) && $stable(i_blue))

    // With nothing at the output every stage is free, so input must be ready
    `HSVR_ASSERT_IMPL(a_empty_ready, i_clk, i_rst_n, !i_out_valid, i_in_ready)

endmodule

bind hsv_to_rgb_converter hsvr_checker u_hsvr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_rgb.valid),
    .i_out_ready (o_rgb.ready),
    .i_red       (o_rgb.red),
    .i_green     (o_rgb.green),
    .i_blue      (o_rgb.blue)
);
